// ===== rtl/hdtw_pkg.sv =====
// ============================================================================
// hdtw_pkg: shared types and constants of the Huffman table-walk decoder
// Field widths, operation and register codes, and the structs passed
// between the front end, the walk engine and the top level.
// ============================================================================
package hdtw_pkg;

    // Fixed field widths.
    localparam int IDX_BITS    = 9;
    localparam int SYM_BITS    = 8;
    localparam int WORD_BITS   = 32;
    localparam int CNT_BITS    = 6;
    localparam int TABLE_DEPTH = 512;

    // Command queue between the front end and the walk engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Operation codes carried in the request's tuser.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ROOT_INDEX = 1'b0;
    localparam logic CFG_LEAF_COUNT = 1'b1;

    // Register reset values.
    localparam logic [IDX_BITS-1:0] ROOT_RESET = 9'd510;
    localparam logic [IDX_BITS-1:0] LEAF_RESET = 9'd256;

    // One classified request as held in the command queue.
    typedef struct packed {
        logic                is_decode;
        logic [IDX_BITS-1:0] node_address;
        logic [IDX_BITS-1:0] left_child;
        logic [IDX_BITS-1:0] right_child;
        logic [SYM_BITS-1:0] symbol_value;
        logic [WORD_BITS-1:0] code_word;
        logic [CNT_BITS-1:0] bit_count;
        logic                restart;
    } t_cmd;

    // Configuration register values.
    typedef struct packed {
        logic [IDX_BITS-1:0] root_index;
        logic [IDX_BITS-1:0] leaf_count;
    } t_cfg;

    // Children of one table node.
    typedef struct packed {
        logic [IDX_BITS-1:0] left;
        logic [IDX_BITS-1:0] right;
    } t_children;

    // Walk engine states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_DRAIN,
        BK_FINISH
    } t_bk_state;

endpackage

// ===== rtl/hdtw_front.sv =====
// ============================================================================
// hdtw_front: request intake and command queue
// Unpacks each accepted request, marks decode against table write, clamps
// the bit count to the word width and holds the result in a short queue.
// ============================================================================
module hdtw_front
    import hdtw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // node_address, left_child, right_child, symbol_value, code_word,
    // bit_count, restart, zero fill
    input  logic [79:0] s_axis_tdata,
    // operation
    input  logic        s_axis_tuser,
    output t_cmd        o_cmd,
    output logic        o_cmd_valid,
    input  logic        i_pop
);

    t_cmd                 r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    t_cmd                 in_cmd;
    logic [CNT_BITS-1:0]  raw_count;
    logic                 push;

    // Unpack the request and clamp the bit count.
    always_comb begin
        raw_count             = s_axis_tdata[72:67];
        in_cmd.is_decode      = (s_axis_tuser == OP_DECODE);
        in_cmd.node_address   = s_axis_tdata[8:0];
        in_cmd.left_child     = s_axis_tdata[17:9];
        in_cmd.right_child    = s_axis_tdata[26:18];
        in_cmd.symbol_value   = s_axis_tdata[34:27];
        in_cmd.code_word      = s_axis_tdata[66:35];
        in_cmd.bit_count      = (raw_count > CNT_BITS'(WORD_BITS)) ?
                                CNT_BITS'(WORD_BITS) : raw_count;
        in_cmd.restart        = s_axis_tdata[73];
    end

    assign s_axis_tready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_cmd         = r_q[r_rd_ptr];
    assign o_cmd_valid   = (r_count != '0);

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            if (push && !i_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (!push && i_pop) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("command popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> (r_count == $past(r_count) + QCNT_BITS'(1)))
        else $error("queue count did not follow a lone push");
`endif

endmodule

// ===== rtl/hdtw_back.sv =====
// ============================================================================
// hdtw_back: node table and tree walk engine
// Holds the node table, walks it one code bit per cycle unless the output
// stalls, fetches leaf symbols and delivers them through an output register,
// marking the last symbol of each word.
// ============================================================================
module hdtw_back
    import hdtw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_pop,
    input  t_cfg                i_cfg,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // decoded_symbol
    output logic [SYM_BITS-1:0] o_m_tdata,
    output logic                o_m_tlast
);

    // Node table: children in one memory, symbols in a second one so the
    // leaf symbol and the next node can be read in the same cycle.
    t_children           node_mem [TABLE_DEPTH];
    logic [SYM_BITS-1:0] sym_mem  [TABLE_DEPTH];

    t_bk_state            r_state, n_state;
    logic [IDX_BITS-1:0]  r_walk, n_walk;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [CNT_BITS-1:0]  r_bits_left, n_bits_left;
    logic                 r_sym_v, n_sym_v;
    logic                 r_hold_v, n_hold_v;
    logic [SYM_BITS-1:0]  r_hold_sym, n_hold_sym;
    t_children            r_node_rd;
    logic [SYM_BITS-1:0]  r_sym_rd;
    logic                 r_out_v;
    logic [SYM_BITS-1:0]  r_out_sym;
    logic                 r_out_last;

    logic                 en;
    logic                 mem_we;
    logic                 node_re;
    logic [IDX_BITS-1:0]  node_raddr;
    logic                 sym_re;
    logic [IDX_BITS-1:0]  start_idx;
    logic [IDX_BITS-1:0]  next_idx;
    logic                 is_leaf;
    logic [IDX_BITS-1:0]  step_walk;
    logic                 push;
    logic [SYM_BITS-1:0]  push_sym;
    logic                 push_last;

    // The whole engine advances only when the output register can move.
    assign en = !r_out_v || i_m_tready;

    // One walk step: pick a child by the leading bit, test for a leaf.
    assign next_idx  = r_word[WORD_BITS-1] ? r_node_rd.right : r_node_rd.left;
    assign is_leaf   = (next_idx < i_cfg.leaf_count);
    assign step_walk = is_leaf ? i_cfg.root_index : next_idx;
    assign start_idx = i_cmd.restart ? i_cfg.root_index : r_walk;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (en && i_cmd_valid && i_cmd.is_decode && (i_cmd.bit_count != '0)) begin
                    n_state = BK_WALK;
                end
            end
            BK_WALK: begin
                if (en && (r_bits_left == CNT_BITS'(1))) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (en) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (en) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Datapath controls and next values.
    always_comb begin
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        node_re     = 1'b0;
        node_raddr  = r_walk;
        sym_re      = 1'b0;
        n_walk      = r_walk;
        n_word      = r_word;
        n_bits_left = r_bits_left;
        n_sym_v     = r_sym_v;
        n_hold_v    = r_hold_v;
        n_hold_sym  = r_hold_sym;
        push        = 1'b0;
        push_sym    = r_hold_sym;
        push_last   = 1'b0;

        // A fetched symbol replaces the held one, which goes out as not last.
        if (en && r_sym_v) begin
            push       = r_hold_v;
            n_hold_sym = r_sym_rd;
            n_hold_v   = 1'b1;
        end

        case (r_state)
            BK_IDLE: begin
                if (en && i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (!i_cmd.is_decode) begin
                        mem_we = 1'b1;
                    end else begin
                        n_walk = start_idx;
                        if (i_cmd.bit_count != '0) begin
                            node_re     = 1'b1;
                            node_raddr  = start_idx;
                            n_word      = i_cmd.code_word;
                            n_bits_left = i_cmd.bit_count;
                        end
                    end
                end
            end
            BK_WALK: begin
                if (en) begin
                    node_re     = 1'b1;
                    node_raddr  = step_walk;
                    n_walk      = step_walk;
                    sym_re      = is_leaf;
                    n_sym_v     = is_leaf;
                    n_word      = {r_word[WORD_BITS-2:0], 1'b0};
                    n_bits_left = r_bits_left - CNT_BITS'(1);
                end
            end
            BK_DRAIN: begin
                if (en) begin
                    n_sym_v = 1'b0;
                end
            end
            BK_FINISH: begin
                // The symbol still held is the last one of the word.
                if (en && r_hold_v) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_hold_v  = 1'b0;
                end
            end
            default: begin
                n_sym_v = 1'b0;
            end
        endcase
    end

    // Node table write and registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            node_mem[i_cmd.node_address] <= '{left: i_cmd.left_child,
                                              right: i_cmd.right_child};
            sym_mem[i_cmd.node_address]  <= i_cmd.symbol_value;
        end
        if (node_re) begin
            r_node_rd <= node_mem[node_raddr];
        end
        if (sym_re) begin
            r_sym_rd <= sym_mem[next_idx];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_walk   <= ROOT_RESET;
            r_sym_v  <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_walk   <= n_walk;
            r_sym_v  <= n_sym_v;
            r_hold_v <= n_hold_v;
            if (en) begin
                r_out_v <= push;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_word      <= n_word;
        r_bits_left <= n_bits_left;
        r_hold_sym  <= n_hold_sym;
        if (en && push) begin
            r_out_sym  <= push_sym;
            r_out_last <= push_last;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_sym;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_sym_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sym_v |-> (r_state == BK_WALK || r_state == BK_DRAIN))
        else $error("symbol fetch pending outside a word");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE) |-> !r_hold_v)
        else $error("held symbol left over after a word");

    a_walk_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_WALK) |-> (r_bits_left != '0))
        else $error("walking with no bits left");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == BK_IDLE && i_cmd_valid))
        else $error("command taken while busy");
`endif

endmodule

// ===== rtl/huffman_decoder_table_walk.sv =====
// ============================================================================
// huffman_decoder_table_walk: Huffman decoder walking a stored node table
// Table writes load node entries; decode requests carry a code word that is
// walked bit by bit from the most significant end, one symbol per leaf.
// ============================================================================
//
// Channel   Direction  Handshake              Content
// s_axis    in         tvalid/tready          tuser op, tdata node or code word
// m_axis    out        tvalid/tready          tdata symbol, tlast end of word
// cfg       in         i_cfg_wr_en only       root index, leaf count
//
// The walk engine takes a table write or a zero-count word in the idle state;
// a decode request passes through the walk, drain and finish states, with one
// node table read per bit, each read address depending on the data of the
// previous read. Reset is synchronous and active low; the node table is
// not cleared. A stalled output freezes the walk engine while the command
// queue keeps accepting up to four requests.
// ============================================================================
module huffman_decoder_table_walk
    import hdtw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // node_address, left_child, right_child, symbol_value, code_word,
    // bit_count, restart, zero fill
    input  logic [79:0]         s_axis_tdata,
    // operation
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // decoded_symbol
    output logic [SYM_BITS-1:0] m_axis_tdata,
    // last_of_word
    output logic                m_axis_tlast,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic [IDX_BITS-1:0] i_cfg_wdata
);

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;
    t_cfg cfg;
    logic [IDX_BITS-1:0] r_root_index;
    logic [IDX_BITS-1:0] r_leaf_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_index <= ROOT_RESET;
            r_leaf_count <= LEAF_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ROOT_INDEX: r_root_index <= i_cfg_wdata;
                CFG_LEAF_COUNT: r_leaf_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.root_index = r_root_index;
    assign cfg.leaf_count = r_leaf_count;

    hdtw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd         (cmd),
        .o_cmd_valid   (cmd_valid),
        .i_pop         (cmd_pop)
    );

    hdtw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_pop       (cmd_pop),
        .i_cfg       (cfg),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

// ===== verif/tb_huffman_decoder_table_walk.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_huffman_decoder_table_walk: self-checking bench for the table-walk decoder
// Loads node tables and code trees through the request stream, moves the root
// and leaf-count registers between phases, and checks every decoded symbol and
// its end-of-word flag against a bench-side walk of the same node table or a typed expectation.
// ============================================================================
module tb_huffman_decoder_table_walk;
    import hdtw_pkg::*;

    localparam int DRAIN_CYCLES = 200;   // four queued full words plus output path
    localparam int IDLE_LIMIT   = 3000;  // cycles without any handshake

    // One decoded symbol as it leaves the block.
    typedef struct packed {
        logic [SYM_BITS-1:0] sym;
        logic                last;
    } t_symbol_out;

    // One request plus an optional typed expectation (n_typed < 0: none).
    typedef struct {
        t_cmd                cmd;
        int                  n_typed;
        logic [SYM_BITS-1:0] sym_typed;
    } t_row;

    // Receiver back-pressure patterns.
    typedef enum int {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_TOGGLE
    } t_ready_mode;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // node_address, left_child, right_child, symbol_value, code_word,
    // bit_count, restart, zero fill
    logic [79:0]         s_axis_tdata  = '0;
    // operation
    logic                s_axis_tuser  = OP_WRITE;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // decoded_symbol
    logic [SYM_BITS-1:0] m_axis_tdata;
    // last_of_word
    logic                m_axis_tlast;
    logic                i_cfg_wr_en   = 1'b0;
    logic                i_cfg_index   = CFG_ROOT_INDEX;
    logic [IDX_BITS-1:0] i_cfg_wdata   = '0;

    // Bench copy of the node table, the walk and the registers.
    logic [IDX_BITS-1:0] tbl_left  [TABLE_DEPTH];
    logic [IDX_BITS-1:0] tbl_right [TABLE_DEPTH];
    logic [SYM_BITS-1:0] tbl_sym   [TABLE_DEPTH];
    logic [IDX_BITS-1:0] walk_pos  = ROOT_RESET;
    logic [IDX_BITS-1:0] cur_root  = ROOT_RESET;
    logic [IDX_BITS-1:0] cur_leaf  = LEAF_RESET;

    // Entries written so far; random children are drawn from these only,
    // so every walk reads written nodes.
    bit          written_flag [TABLE_DEPTH];
    int          written_nodes[$];

    t_symbol_out pending_symbols[$];
    t_symbol_out head;
    t_row        directed_rows[$];
    bit          mismatch_seen = 1'b0;
    int          burst_left    = 0;
    int          idle_cycles   = 0;
    int          mode_left     = 0;
    t_ready_mode stall_mode    = RDY_ALWAYS;

    huffman_decoder_table_walk dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Table write request; the decode fields carry random filler.
    function automatic t_row mk_write(input logic [IDX_BITS-1:0] addr,
                                      input logic [IDX_BITS-1:0] left,
                                      input logic [IDX_BITS-1:0] right,
                                      input logic [SYM_BITS-1:0] sym);
        t_row r;
        r.cmd.is_decode    = OP_WRITE;
        r.cmd.node_address = addr;
        r.cmd.left_child   = left;
        r.cmd.right_child  = right;
        r.cmd.symbol_value = sym;
        r.cmd.code_word    = $urandom;
        r.cmd.bit_count    = CNT_BITS'($urandom_range(0, 63));
        r.cmd.restart      = 1'($urandom_range(0, 1));
        r.n_typed          = -1;
        r.sym_typed        = '0;
        return r;
    endfunction

    // Decode request; the node fields carry random filler.
    function automatic t_row mk_decode(input logic [WORD_BITS-1:0] word,
                                       input logic [CNT_BITS-1:0]  cnt,
                                       input logic                 restart,
                                       input int                   n_typed,
                                       input logic [SYM_BITS-1:0]  sym_typed);
        t_row r;
        r.cmd.is_decode    = OP_DECODE;
        r.cmd.node_address = IDX_BITS'($urandom_range(0, 511));
        r.cmd.left_child   = IDX_BITS'($urandom_range(0, 511));
        r.cmd.right_child  = IDX_BITS'($urandom_range(0, 511));
        r.cmd.symbol_value = SYM_BITS'($urandom_range(0, 255));
        r.cmd.code_word    = word;
        r.cmd.bit_count    = cnt;
        r.cmd.restart      = restart;
        r.n_typed          = n_typed;
        r.sym_typed        = sym_typed;
        return r;
    endfunction

    // Random table index among the entries written so far.
    function automatic logic [IDX_BITS-1:0] pick_written();
        return IDX_BITS'(written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
    endfunction

    // Apply one accepted request to the bench table and queue the symbols
    // that its bits complete. A typed expectation replaces the walked one.
    task automatic walk_request(input t_row r);
        t_symbol_out         found[$];
        t_symbol_out         s;
        int                  nbits;
        logic [IDX_BITS-1:0] nxt;
        if (r.cmd.is_decode == OP_WRITE) begin
            tbl_left[r.cmd.node_address]  = r.cmd.left_child;
            tbl_right[r.cmd.node_address] = r.cmd.right_child;
            tbl_sym[r.cmd.node_address]   = r.cmd.symbol_value;
            if (!written_flag[r.cmd.node_address]) begin
                written_flag[r.cmd.node_address] = 1'b1;
                written_nodes.push_back(int'(r.cmd.node_address));
            end
        end else begin
            if (r.cmd.restart)
                walk_pos = cur_root;
            nbits = (r.cmd.bit_count > WORD_BITS) ? WORD_BITS : r.cmd.bit_count;
            for (int k = 0; k < nbits; k++) begin
                nxt = r.cmd.code_word[WORD_BITS-1-k] ? tbl_right[walk_pos]
                                                     : tbl_left[walk_pos];
                if (nxt < cur_leaf) begin
                    s.sym  = tbl_sym[nxt];
                    s.last = 1'b0;
                    found.push_back(s);
                    walk_pos = cur_root;
                end else begin
                    walk_pos = nxt;
                end
            end
            if (r.n_typed >= 0) begin
                found.delete();
                s.sym  = r.sym_typed;
                s.last = 1'b0;
                for (int k = 0; k < r.n_typed; k++)
                    found.push_back(s);
            end
            if (found.size() > 0)
                found[found.size()-1].last = 1'b1;
            foreach (found[k])
                pending_symbols.push_back(found[k]);
        end
    endtask

    // Present one request in the current burst and wait for its handshake.
    task automatic issue(input t_row r);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd.is_decode;
        s_axis_tdata  <= {6'b0, r.cmd.restart, r.cmd.bit_count, r.cmd.code_word,
                          r.cmd.symbol_value, r.cmd.right_child, r.cmd.left_child,
                          r.cmd.node_address};
        do @(posedge i_clk); while (!s_axis_tready);
        walk_request(r);
        burst_left--;
        if (burst_left == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    // Stop sending and let the block finish everything it holds.
    task automatic wait_drained();
        if (burst_left != 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the root index register, then the leaf-count register.
    task automatic write_regs(input logic [IDX_BITS-1:0] root,
                              input logic [IDX_BITS-1:0] leaf);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_ROOT_INDEX;
        i_cfg_wdata <= root;
        @(posedge i_clk);
        i_cfg_index <= CFG_LEAF_COUNT;
        i_cfg_wdata <= leaf;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_root = root;
        cur_leaf = leaf;
    endtask

    // Build a random code tree under a new root and leaf count, then decode
    // random words through it with a little table noise mixed in.
    task automatic run_tree_phase(input int leaf_sel, input int root_sel,
                                  input int n_words);
        bit         taken [TABLE_DEPTH];
        int         pool[$];
        int         n_leaves, idx, tries, root_node, left_sub, right_sub, sel;
        logic [5:0] cnt;
        logic       rs;
        wait_drained();
        root_node = (root_sel >= 0) ? root_sel : $urandom_range(leaf_sel, 510);
        taken[root_node] = 1'b1;
        write_regs(IDX_BITS'(root_node), IDX_BITS'(leaf_sel));

        // Leaves sit below the leaf count; repeats are allowed when few exist.
        n_leaves = $urandom_range(2, 9);
        for (int i = 0; i < n_leaves; i++) begin
            tries = 0;
            do begin
                idx = $urandom_range(0, leaf_sel - 1);
                tries++;
            end while (taken[idx] && tries < 8);
            taken[idx] = 1'b1;
            pool.push_back(idx);
            issue(mk_write(IDX_BITS'(idx), pick_written(), pick_written(),
                           SYM_BITS'($urandom_range(0, 255))));
        end

        // Join subtrees pairwise; the last join lands on the root.
        while (pool.size() > 1) begin
            idx = $urandom_range(0, pool.size() - 1);
            left_sub = pool[idx];
            pool.delete(idx);
            idx = $urandom_range(0, pool.size() - 1);
            right_sub = pool[idx];
            pool.delete(idx);
            if (pool.size() == 0) begin
                idx = root_node;
            end else begin
                do idx = $urandom_range(leaf_sel, 511); while (taken[idx]);
                taken[idx] = 1'b1;
            end
            issue(mk_write(IDX_BITS'(idx), IDX_BITS'(left_sub), IDX_BITS'(right_sub),
                           SYM_BITS'($urandom_range(0, 255))));
            pool.push_back(idx);
        end

        // The first word may keep the walk left over from the last phase.
        for (int j = 0; j < n_words; j++) begin
            if ($urandom_range(0, 19) == 0) begin
                issue(mk_write(IDX_BITS'($urandom_range(0, 511)), pick_written(),
                               pick_written(), SYM_BITS'($urandom_range(0, 255))));
            end else begin
                sel = $urandom_range(0, 19);
                cnt = (sel == 0) ? 6'd0 :
                      (sel == 1) ? 6'($urandom_range(33, 63)) :
                                   6'($urandom_range(1, 32));
                rs  = (j == 0) ? 1'($urandom_range(0, 1))
                               : ($urandom_range(0, 7) == 0);
                issue(mk_decode($urandom, cnt, rs, -1, '0));
            end
        end
    endtask

    // Main sequence: reset, directed table, tree phases.
    initial begin
        // Two-leaf tree at the reset root: zero goes to node 0, one to node 1.
        directed_rows.push_back(mk_write(9'd510, 9'd0, 9'd1, 8'h00));
        directed_rows.push_back(mk_write(9'd0, 9'd0, 9'd0, 8'h00));
        directed_rows.push_back(mk_write(9'd1, 9'd1, 9'd1, 8'hFF));
        directed_rows.push_back(mk_write(9'd511, 9'd511, 9'd0, 8'hA5));
        directed_rows.push_back(mk_decode(32'h0000_0000, 6'd32, 1'b1, 32, 8'h00));
        directed_rows.push_back(mk_decode(32'hFFFF_FFFF, 6'd32, 1'b0, 32, 8'hFF));
        // An empty word yields nothing; an oversized count saturates.
        directed_rows.push_back(mk_decode(32'hFFFF_FFFF, 6'd0, 1'b1, 0, 8'h00));
        directed_rows.push_back(mk_decode(32'hFFFF_FFFF, 6'd63, 1'b0, 32, 8'hFF));
        directed_rows.push_back(mk_decode(32'h8000_0000, 6'd1, 1'b0, 1, 8'hFF));
        directed_rows.push_back(mk_decode(32'h7FFF_FFFF, 6'd1, 1'b0, 1, 8'h00));
        // Deeper tree: zero leads to an inner node at 509.
        directed_rows.push_back(mk_write(9'd509, 9'd1, 9'd0, 8'h5A));
        directed_rows.push_back(mk_write(9'd510, 9'd509, 9'd1, 8'h3C));
        directed_rows.push_back(mk_decode(32'h6D00_0000, 6'd8, 1'b1, -1, '0));
        // A code split across words, then a restart in the middle of a code.
        directed_rows.push_back(mk_decode(32'h0000_0000, 6'd1, 1'b0, -1, '0));
        directed_rows.push_back(mk_decode(32'h8000_0000, 6'd1, 1'b0, -1, '0));
        directed_rows.push_back(mk_decode(32'h0000_0000, 6'd1, 1'b0, -1, '0));
        directed_rows.push_back(mk_decode(32'h8000_0000, 6'd1, 1'b1, -1, '0));
        directed_rows.push_back(mk_decode(32'hA5A5_A5A5, 6'd33, 1'b0, -1, '0));
        directed_rows.push_back(mk_decode(32'h1234_5678, 6'd32, 1'b0, -1, '0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i]);

        run_tree_phase(1, 510, 24);
        run_tree_phase(256, 256, 24);
        run_tree_phase(256, 0, 24);
        run_tree_phase(128, -1, 24);
        for (int p = 0; p < 4; p++)
            run_tree_phase($urandom_range(1, 256), -1, 24);

        wait_drained();
        if (!mismatch_seen)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Receiver back-pressure: a random pattern, redrawn when its random span runs out.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 120);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            RDY_ALWAYS: begin
                m_axis_tready <= 1'b1;
            end
            RDY_MOSTLY: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            RDY_RARELY: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= ~m_axis_tready;
            end
        endcase
    end

    // Compare each delivered symbol with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_symbols.size() == 0) begin
                $display("%0t: unexpected symbol: expected none, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatch_seen = 1'b1;
            end else begin
                head = pending_symbols.pop_front();
                if (m_axis_tdata !== head.sym) begin
                    $display("%0t: symbol mismatch: expected %h, actual %h",
                             $time, head.sym, m_axis_tdata);
                    mismatch_seen = 1'b1;
                end
                if (m_axis_tlast !== head.last) begin
                    $display("%0t: end-of-word mismatch: expected %b, actual %b",
                             $time, head.last, m_axis_tlast);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d symbols outstanding",
                     $time, IDLE_LIMIT, pending_symbols.size());
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/hdtw_pkg.sv
rtl/hdtw_front.sv
rtl/hdtw_back.sv
rtl/huffman_decoder_table_walk.sv
verif/tb_huffman_decoder_table_walk.sv
